FILE: design/first_fit_block_allocator_assert.svh
// Assertion macros used by the checker module.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FFBA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FFBA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

FILE: design/ffba_pkg.sv
`default_nettype none
package ffba_pkg;

	// Fixed field widths of the request and result
	localparam int SIZE_W = 21;
	localparam int ADDR_W = 32;
	localparam int STAT_W = 3;
	localparam int REQ_W  = 22;

	localparam int HDR_BYTES   = 12;
	localparam int SPLIT_SLACK = 16;
	localparam int ALIGN_MASK  = 15;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_DONE    = 3'd0;
	localparam logic [STAT_W-1:0] ST_NO_FIT  = 3'd1;
	localparam logic [STAT_W-1:0] ST_ZERO    = 3'd2;
	localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd3;
	localparam logic [STAT_W-1:0] ST_NULL    = 3'd4;

	// Datapath operations
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NOP        = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD       = 5'd1;
	localparam logic [OP_W-1:0] OP_READ_IDX   = 5'd2;
	localparam logic [OP_W-1:0] OP_SCAN_NEXT  = 5'd3;
	localparam logic [OP_W-1:0] OP_TAKE       = 5'd4;
	localparam logic [OP_W-1:0] OP_FINISH     = 5'd5;
	localparam logic [OP_W-1:0] OP_UP_READ    = 5'd6;
	localparam logic [OP_W-1:0] OP_UP_WRITE   = 5'd7;
	localparam logic [OP_W-1:0] OP_TAIL_WRITE = 5'd8;
	localparam logic [OP_W-1:0] OP_HEAD_WRITE = 5'd9;
	localparam logic [OP_W-1:0] OP_MARK_WRITE = 5'd10;
	localparam logic [OP_W-1:0] OP_MRG_INIT   = 5'd11;
	localparam logic [OP_W-1:0] OP_MRG_LOAD   = 5'd12;
	localparam logic [OP_W-1:0] OP_MRG_READ   = 5'd13;
	localparam logic [OP_W-1:0] OP_MRG_JOIN   = 5'd14;
	localparam logic [OP_W-1:0] OP_MRG_STEP   = 5'd15;
	localparam logic [OP_W-1:0] OP_SH_READ    = 5'd16;
	localparam logic [OP_W-1:0] OP_SH_WRITE   = 5'd17;
	localparam logic [OP_W-1:0] OP_MRG_SHRINK = 5'd18;
	localparam logic [OP_W-1:0] OP_MRG_LAST   = 5'd19;

	typedef struct packed {
		logic              mode;
		logic [SIZE_W-1:0] request_size;
		logic [ADDR_W-1:0] payload_address;
	} alloc_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] result_address;
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] heap_top;
	} alloc_rsp_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [STAT_W-1:0] stat;
	} dp_cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic req_zero;
		logic pa_null;
		logic scan_end;
		logic off_hit;
		logic fit;
		logic split;
		logic up_more;
		logic mrg_more;
		logic both_free;
		logic shift_more;
	} dp_status_t;

endpackage
`default_nettype wire

FILE: design/first_fit_block_allocator.sv
`default_nettype none
// First-fit heap allocator over an address-ordered block table.
// Requests: drive request and pulse start while busy is low; the request is
// taken at that edge and busy rises. mode 0 allocates request_size bytes,
// mode 1 frees payload_address.
// Results: done is high for exactly one cycle with result valid; the
// receiver cannot stall it. busy is already low in that cycle, so the next
// request may be taken there.
// Flow: a zero-size allocate or null free finishes right after the check.
// Otherwise the first-fit scan visits the table entries in order, a split
// insert moves entries up one at a time, and a free runs a merge pass over
// the whole table, moving entries down after each merge, with up to two
// merges. The table sits in one RAM with a single read and write port pair.
// Configuration: cfg_we writes heap_base (rounded up to 16). The user must
// write it only while idle; the block does not enforce this.
// Reset: one free block spans the heap, heap_top equals the base, base is 0.
module first_fit_block_allocator import ffba_pkg::*; #(
	parameter int HEAP_BYTES = 1048576,
	parameter int MAX_BLOCKS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [ADDR_W-1:0] cfg_wdata,
	input  wire logic              start,
	output logic                   busy,
	input  wire alloc_req_t        request,
	output logic                   done,
	output alloc_rsp_t             result
);

	dp_cmd_t    cmd;
	dp_status_t st;

	ffba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd)
	);

	ffba_dp #(.HEAP_BYTES(HEAP_BYTES), .MAX_BLOCKS(MAX_BLOCKS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_in    (request),
		.cmd       (cmd),
		.st        (st),
		.done      (done),
		.rsp       (result)
	);

endmodule
`default_nettype wire

FILE: design/ffba_ram.sv
`default_nettype none
module ffba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: design/ffba_ctrl.sv
`default_nettype none
module ffba_ctrl import ffba_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire dp_status_t st,
	output dp_cmd_t         cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_CHECK    = 4'd1;
	localparam logic [3:0] S_SCAN     = 4'd2;
	localparam logic [3:0] S_SCAN_CHK = 4'd3;
	localparam logic [3:0] S_SPLIT    = 4'd4;
	localparam logic [3:0] S_UP_WR    = 4'd5;
	localparam logic [3:0] S_HEAD     = 4'd6;
	localparam logic [3:0] S_FIN      = 4'd7;
	localparam logic [3:0] S_MARK_WR  = 4'd8;
	localparam logic [3:0] S_MRG_INIT = 4'd9;
	localparam logic [3:0] S_MRG_LOAD = 4'd10;
	localparam logic [3:0] S_MRG_RD   = 4'd11;
	localparam logic [3:0] S_MRG_CHK  = 4'd12;
	localparam logic [3:0] S_SH       = 4'd13;
	localparam logic [3:0] S_SH_WR    = 4'd14;

	logic [3:0] state_q, state_d;

	assign busy = (state_q != S_IDLE);

	// Sequence the datapath through scan, split and merge
	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NOP;
		cmd.stat = ST_DONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.is_alloc && st.req_zero) begin
					cmd.op   = OP_FINISH;
					cmd.stat = ST_ZERO;
					state_d  = S_IDLE;
				end else if (!st.is_alloc && st.pa_null) begin
					cmd.op   = OP_FINISH;
					cmd.stat = ST_NULL;
					state_d  = S_IDLE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (st.scan_end) begin
					cmd.op   = OP_FINISH;
					cmd.stat = st.is_alloc ? ST_NO_FIT : ST_UNKNOWN;
					state_d  = S_IDLE;
				end else if (!st.is_alloc && st.off_hit) begin
					cmd.op  = OP_READ_IDX;
					state_d = S_MARK_WR;
				end else begin
					cmd.op  = OP_READ_IDX;
					state_d = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				if (st.is_alloc && st.fit) begin
					cmd.op  = OP_TAKE;
					state_d = S_SPLIT;
				end else begin
					cmd.op  = OP_SCAN_NEXT;
					state_d = S_SCAN;
				end
			end
			S_SPLIT: begin
				if (!st.split) begin
					cmd.op  = OP_HEAD_WRITE;
					state_d = S_FIN;
				end else if (st.up_more) begin
					cmd.op  = OP_UP_READ;
					state_d = S_UP_WR;
				end else begin
					cmd.op  = OP_TAIL_WRITE;
					state_d = S_HEAD;
				end
			end
			S_UP_WR: begin
				cmd.op  = OP_UP_WRITE;
				state_d = S_SPLIT;
			end
			S_HEAD: begin
				cmd.op  = OP_HEAD_WRITE;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.op   = OP_FINISH;
				cmd.stat = ST_DONE;
				state_d  = S_IDLE;
			end
			S_MARK_WR: begin
				cmd.op  = OP_MARK_WRITE;
				state_d = S_MRG_INIT;
			end
			S_MRG_INIT: begin
				cmd.op  = OP_MRG_INIT;
				state_d = S_MRG_LOAD;
			end
			S_MRG_LOAD: begin
				cmd.op  = OP_MRG_LOAD;
				state_d = S_MRG_RD;
			end
			S_MRG_RD: begin
				if (st.mrg_more) begin
					cmd.op  = OP_MRG_READ;
					state_d = S_MRG_CHK;
				end else begin
					cmd.op  = OP_MRG_LAST;
					state_d = S_FIN;
				end
			end
			S_MRG_CHK: begin
				if (st.both_free) begin
					cmd.op  = OP_MRG_JOIN;
					state_d = S_SH;
				end else begin
					cmd.op  = OP_MRG_STEP;
					state_d = S_MRG_RD;
				end
			end
			S_SH: begin
				if (st.shift_more) begin
					cmd.op  = OP_SH_READ;
					state_d = S_SH_WR;
				end else begin
					cmd.op  = OP_MRG_SHRINK;
					state_d = S_MRG_RD;
				end
			end
			S_SH_WR: begin
				cmd.op  = OP_SH_WRITE;
				state_d = S_SH;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

FILE: design/ffba_dp.sv
`default_nettype none
module ffba_dp import ffba_pkg::*; #(
	parameter int HEAP_BYTES = 1048576,
	parameter int MAX_BLOCKS = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [ADDR_W-1:0] cfg_wdata,
	input  wire alloc_req_t        req_in,
	input  wire dp_cmd_t           cmd,
	output dp_status_t             st,
	output logic                   done,
	output alloc_rsp_t             rsp
);

	localparam int SW   = $clog2(HEAP_BYTES);
	localparam int OW   = $clog2(HEAP_BYTES + 1);
	localparam int IW   = $clog2(MAX_BLOCKS);
	localparam int CW   = $clog2(MAX_BLOCKS + 1);
	localparam int DW   = SW + 1;
	localparam int CMPW = ((SW > REQ_W) ? SW : REQ_W) + 1;
	localparam logic [SW-1:0] INIT_SIZE = SW'(HEAP_BYTES - HDR_BYTES);

	logic [ADDR_W-1:0] base_q, target_q, addr_q;
	logic              mode_q, zero_q, null_q;
	logic [REQ_W-1:0]  req_q;
	logic [CW-1:0]     idx_q, j_q, cnt_q;
	logic [CW-1:0]     idx_p1, j_p1, j_m1;
	logic [OW-1:0]     off_q, top_q;
	logic [SW-1:0]     cur_size_q, head_size;
	logic              cur_free_q, split_q, init_q, rd0_q;
	logic              done_q;
	alloc_rsp_t        rsp_q;

	logic              ram_we, ram_re;
	logic [IW-1:0]     ram_waddr, ram_raddr;
	logic [DW-1:0]     ram_wdata, ram_rdata, rd_word;
	logic [SW-1:0]     rd_size;
	logic              rd_free;

	ffba_ram #(.WIDTH(DW), .DEPTH(MAX_BLOCKS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Entry zero reads as the whole free heap until first written
	assign rd_word = rd0_q ? {1'b1, INIT_SIZE} : ram_rdata;
	assign rd_free = rd_word[SW];
	assign rd_size = rd_word[SW-1:0];

	assign idx_p1    = idx_q + 1'b1;
	assign j_p1      = j_q + 1'b1;
	assign j_m1      = j_q - 1'b1;
	assign head_size = split_q ? SW'(req_q) : cur_size_q;

	// Status for the controller
	always_comb begin
		st.is_alloc   = !mode_q;
		st.req_zero   = zero_q;
		st.pa_null    = null_q;
		st.scan_end   = (idx_q >= cnt_q);
		st.off_hit    = (ADDR_W'(off_q) == target_q);
		st.fit        = rd_free && (CMPW'(rd_size) >= CMPW'(req_q));
		st.split      = split_q;
		st.up_more    = (j_q > idx_p1);
		st.mrg_more   = (idx_p1 < cnt_q);
		st.both_free  = cur_free_q && rd_free;
		st.shift_more = (j_p1 < cnt_q);
	end

	// Drive the table ports
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = idx_q[IW-1:0];
		ram_raddr = idx_q[IW-1:0];
		ram_wdata = {cur_free_q, cur_size_q};
		case (cmd.op)
			OP_READ_IDX: begin
				ram_re = 1'b1;
			end
			OP_UP_READ: begin
				ram_re    = 1'b1;
				ram_raddr = j_m1[IW-1:0];
			end
			OP_MRG_INIT: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			OP_MRG_READ: begin
				ram_re    = 1'b1;
				ram_raddr = idx_p1[IW-1:0];
			end
			OP_SH_READ: begin
				ram_re    = 1'b1;
				ram_raddr = j_p1[IW-1:0];
			end
			OP_UP_WRITE, OP_SH_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = j_q[IW-1:0];
				ram_wdata = rd_word;
			end
			OP_TAIL_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = idx_p1[IW-1:0];
				ram_wdata = {1'b1, cur_size_q - SW'(req_q) - SW'(HDR_BYTES)};
			end
			OP_HEAD_WRITE: begin
				ram_we    = 1'b1;
				ram_wdata = {1'b0, head_size};
			end
			OP_MARK_WRITE: begin
				ram_we    = 1'b1;
				ram_wdata = {1'b1, rd_size};
			end
			OP_MRG_STEP, OP_MRG_LAST: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Hold table bookkeeping, base and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			cnt_q  <= CW'(1);
			top_q  <= '0;
			init_q <= 1'b1;
			done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_q <= (cfg_wdata + ADDR_W'(ALIGN_MASK)) & ~ADDR_W'(ALIGN_MASK);
			end
			if (ram_we && (ram_waddr == '0)) begin
				init_q <= 1'b0;
			end
			if (cmd.op == OP_HEAD_WRITE) begin
				cnt_q <= cnt_q + CW'(split_q);
				top_q <= off_q + OW'(HDR_BYTES) + OW'(head_size);
			end
			if (cmd.op == OP_MRG_SHRINK) begin
				cnt_q <= cnt_q - 1'b1;
			end
			done_q <= (cmd.op == OP_FINISH);
		end
	end

	// Advance the working registers
	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd0_q <= init_q && (ram_raddr == '0);
		end
		case (cmd.op)
			OP_LOAD: begin
				mode_q   <= req_in.mode;
				zero_q   <= (req_in.request_size == '0);
				null_q   <= (req_in.payload_address == '0);
				req_q    <= (REQ_W'(req_in.request_size) + REQ_W'(ALIGN_MASK))
					& ~REQ_W'(ALIGN_MASK);
				target_q <= req_in.payload_address - base_q - ADDR_W'(HDR_BYTES);
				idx_q    <= '0;
				off_q    <= '0;
				addr_q   <= '0;
			end
			OP_SCAN_NEXT: begin
				off_q <= off_q + OW'(HDR_BYTES) + OW'(rd_size);
				idx_q <= idx_p1;
			end
			OP_TAKE: begin
				cur_size_q <= rd_size;
				split_q    <= (CMPW'(rd_size) > (CMPW'(req_q)
					+ CMPW'(HDR_BYTES + SPLIT_SLACK))) && (cnt_q < CW'(MAX_BLOCKS));
				j_q        <= cnt_q;
			end
			OP_UP_WRITE: begin
				j_q <= j_m1;
			end
			OP_HEAD_WRITE: begin
				addr_q <= base_q + ADDR_W'(off_q) + ADDR_W'(HDR_BYTES);
			end
			OP_MRG_INIT: begin
				idx_q <= '0;
			end
			OP_MRG_LOAD: begin
				cur_size_q <= rd_size;
				cur_free_q <= rd_free;
			end
			OP_MRG_JOIN: begin
				cur_size_q <= cur_size_q + SW'(HDR_BYTES) + rd_size;
				j_q        <= idx_p1;
			end
			OP_MRG_STEP: begin
				cur_size_q <= rd_size;
				cur_free_q <= rd_free;
				idx_q      <= idx_p1;
			end
			OP_SH_WRITE: begin
				j_q <= j_p1;
			end
			OP_FINISH: begin
				rsp_q.result_address <= addr_q;
				rsp_q.status         <= cmd.stat;
				rsp_q.heap_top       <= base_q + ADDR_W'(top_q);
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire

FILE: design/ffba_chk.sv
`default_nettype none
module ffba_chk import ffba_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire alloc_rsp_t result
);

`include "first_fit_block_allocator_assert.svh"

	// An accepted request keeps the block busy
	`FFBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	// One result per request; done is never asserted back to back
	`FFBA_ASSERT_NEXT(a_done_single, done, !done)
	// The block is free to take a new request while a result shows
	`FFBA_ASSERT_NOW(a_done_idle, done, !busy)
	// Requests that end in any status but done report no address
	`FFBA_ASSERT_NOW(a_fail_addr, done && (result.status != ST_DONE), result.result_address == '0)

endmodule

bind first_fit_block_allocator ffba_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
`default_nettype wire

FILE: tb/first_fit_block_allocator_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module first_fit_block_allocator_tb;
	import ffba_pkg::*;

	localparam int ARENA_BYTES = 1048576;
	localparam int TABLE_DEPTH = 64;
	localparam int STALL_LIMIT = 5000;
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ADDR_W-1:0] cfg_wdata;
	logic start;
	logic busy;
	alloc_req_t request;
	logic done;
	alloc_rsp_t result;

	first_fit_block_allocator #(
		.HEAP_BYTES(ARENA_BYTES),
		.MAX_BLOCKS(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	// Heap table mirror
	int unsigned blk_size [TABLE_DEPTH];
	bit blk_free [TABLE_DEPTH];
	int unsigned blk_count;
	int unsigned top_off;
	logic [31:0] base_reg;

	alloc_rsp_t expected_rsp[$];
	int mismatches;
	int idle_cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [31:0] aligned_base();
		return (base_reg + 32'd15) & ~32'd15;
	endfunction

	function automatic logic [31:0] block_start(int unsigned k);
		logic [31:0] off;
		off = 0;
		for (int unsigned i = 0; i < k; i++)
			off += HDR_BYTES + blk_size[i];
		return off;
	endfunction

	function automatic void drop_entry(int unsigned k);
		for (int unsigned i = k; i + 1 < blk_count; i++) begin
			blk_size[i] = blk_size[i + 1];
			blk_free[i] = blk_free[i + 1];
		end
		blk_count--;
	endfunction

	// Work out the response to one request and update the table mirror
	function automatic alloc_rsp_t heap_response(alloc_req_t r);
		alloc_rsp_t rsp;
		logic [31:0] base, off, target, want;
		int unsigned i;
		bit found;
		base = aligned_base();
		rsp.result_address = 0;
		rsp.status = ST_DONE;
		found = 0;
		off = 0;
		if (r.mode == MODE_ALLOC) begin
			want = (32'(r.request_size) + 32'd15) & ~32'd15;
			if (r.request_size == 0) begin
				rsp.status = ST_ZERO;
			end else begin
				for (i = 0; i < blk_count; i++) begin
					if (blk_free[i] && blk_size[i] >= want) begin
						found = 1;
						break;
					end
					off += HDR_BYTES + blk_size[i];
				end
				if (!found) begin
					rsp.status = ST_NO_FIT;
				end else begin
					// Split off the spare tail when room and table allow
					if (blk_size[i] > want + HDR_BYTES + SPLIT_SLACK &&
					    blk_count < TABLE_DEPTH) begin
						for (int unsigned j = blk_count; j > i + 1; j--) begin
							blk_size[j] = blk_size[j - 1];
							blk_free[j] = blk_free[j - 1];
						end
						blk_size[i + 1] = blk_size[i] - want - HDR_BYTES;
						blk_free[i + 1] = 1;
						blk_size[i] = want;
						blk_count++;
					end
					blk_free[i] = 0;
					top_off = off + HDR_BYTES + blk_size[i];
					rsp.result_address = base + off + HDR_BYTES;
				end
			end
		end else if (r.payload_address == 0) begin
			rsp.status = ST_NULL;
		end else begin
			target = r.payload_address - base - HDR_BYTES;
			for (i = 0; i < blk_count; i++) begin
				if (off == target) begin
					found = 1;
					break;
				end
				off += HDR_BYTES + blk_size[i];
			end
			if (!found) begin
				rsp.status = ST_UNKNOWN;
			end else begin
				blk_free[i] = 1;
				// Coalesce neighboring free blocks front to back
				i = 0;
				while (i + 1 < blk_count) begin
					if (blk_free[i] && blk_free[i + 1]) begin
						blk_size[i] += HDR_BYTES + blk_size[i + 1];
						drop_entry(i + 1);
					end else begin
						i++;
					end
				end
			end
		end
		rsp.heap_top = base + top_off;
		return rsp;
	endfunction

	// Send one request and record its expected response at acceptance
	task automatic send_request(logic m, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] pa);
		alloc_req_t r;
		r.mode = m;
		r.request_size = sz;
		r.payload_address = pa;
		@(negedge clk);
		start = 1'b1;
		request = r;
		do @(posedge clk); while (busy);
		expected_rsp.push_back(heap_response(r));
	endtask

	task automatic idle_sender(int n);
		repeat (n) begin
			@(negedge clk);
			start = 1'b0;
			request = '0;
		end
	endtask

	task automatic drain();
		idle_sender(1);
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Write heap_base while idle
	task automatic write_base(logic [31:0] v);
		drain();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		cfg_wdata = $urandom;
		base_reg = v;
	endtask

	function automatic logic [31:0] live_address();
		return aligned_base() + block_start($urandom_range(0, blk_count - 1)) + HDR_BYTES;
	endfunction

	task automatic test_edge_sizes();
		send_request(MODE_ALLOC, 0, 32'hFFFF_FFFF);
		send_request(MODE_ALLOC, 21'h1F_FFFF, 0);
		send_request(MODE_ALLOC, 21'd1048576, 0);
		send_request(MODE_ALLOC, 21'd1048560, 0);
		send_request(MODE_FREE, 0, live_address());
		send_request(MODE_ALLOC, 1, 0);
		send_request(MODE_ALLOC, 17, 0);
	endtask

	task automatic test_free_cases();
		send_request(MODE_FREE, 0, 0);
		send_request(MODE_FREE, 21'h1F_FFFF, 32'h1234_5677);
		send_request(MODE_FREE, 0, aligned_base() + block_start(0) + HDR_BYTES);
		send_request(MODE_FREE, 0, aligned_base() + block_start(0) + HDR_BYTES);
		send_request(MODE_FREE, 0, aligned_base() + block_start(1) + HDR_BYTES);
		send_request(MODE_ALLOC, 40, 0);
	endtask

	// Fill the table so the allocates after it cannot split a block, then free live blocks
	task automatic test_full_table();
		while (blk_count < TABLE_DEPTH)
			send_request(MODE_ALLOC, SIZE_W'($urandom_range(1, 64)), 0);
		send_request(MODE_ALLOC, 16, 0);
		send_request(MODE_ALLOC, 21'd1000, 0);
		for (int k = 0; k < 70; k++)
			send_request(MODE_FREE, 0, live_address());
	endtask

	task automatic test_random(int n, int idle_pct);
		int pick;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < idle_pct)
				idle_sender($urandom_range(1, 8));
			pick = $urandom_range(0, 99);
			if (pick < 45)
				send_request(MODE_ALLOC, SIZE_W'($urandom_range(1, 600)), $urandom);
			else if (pick < 50)
				send_request(MODE_ALLOC, SIZE_W'($urandom_range(0, 1048576)), $urandom);
			else if (pick < 52)
				send_request(MODE_ALLOC, SIZE_W'($urandom), $urandom);
			else if (pick < 90)
				send_request(MODE_FREE, SIZE_W'($urandom), live_address());
			else if (pick < 93)
				send_request(MODE_FREE, SIZE_W'($urandom), 0);
			else
				send_request(MODE_FREE, SIZE_W'($urandom), $urandom);
		end
	endtask

	// Compare each response with the oldest expectation
	always @(posedge clk) begin
		alloc_rsp_t want;
		if (arst_n && done) begin
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response %h", result);
			end else begin
				want = expected_rsp.pop_front();
				if (result.result_address !== want.result_address ||
				    result.status !== want.status ||
				    result.heap_top !== want.heap_top) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: addr %h/%h status %0d/%0d top %h/%h",
							want.result_address, result.result_address,
							want.status, result.status, want.heap_top, result.heap_top);
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		start = 1'b0;
		request = '0;
		base_reg = 0;
		blk_size[0] = ARENA_BYTES - HDR_BYTES;
		blk_free[0] = 1;
		blk_count = 1;
		top_off = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_edge_sizes();
		test_free_cases();
		write_base(32'hFFFF_FFF0);
		test_full_table();
		write_base(32'hFFFF_FFFF);
		test_random(400, 0);
		write_base($urandom);
		test_random(400, 70);
		write_base(32'h0000_0007);
		test_random(400, 38);
		write_base(32'h0000_0000);
		test_random(300, 0);
		drain();
		repeat (300) @(posedge clk);

		if (mismatches == 0 && expected_rsp.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire

FILE: files.f
+incdir+design
design/ffba_pkg.sv
design/ffba_ram.sv
design/ffba_ctrl.sv
design/ffba_dp.sv
design/first_fit_block_allocator.sv
design/ffba_chk.sv
tb/first_fit_block_allocator_tb.sv
